### rtl/core/spi_flash_double_buffer_reader_assert.svh
// Assertion macros for the SPI flash double buffer reader.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef SPI_FLASH_DOUBLE_BUFFER_READER_ASSERT_SVH
`define SPI_FLASH_DOUBLE_BUFFER_READER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SFDBR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfdbr same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SFDBR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfdbr next-cycle check failed");

`endif

### rtl/core/sfdbr_pkg.sv
// Package for the SPI flash double buffer reader: request types, slot type,
// phase encoding and function codes. Depends on nothing.
package sfdbr_pkg;

  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_FILL  = 2'd1;
  localparam logic [1:0] FUNC_BYTE  = 2'd2;

  localparam logic [7:0] READ_CMD_RESET = 8'd3;
  localparam logic [7:0] TX_ZERO        = 8'h00;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ADDR = 2'd1,
    PH_TURN = 2'd2,
    PH_DATA = 2'd3
  } phase_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [23:0] flash_addr;
    logic [23:0] byte_count;
    logic [7:0]  rx_byte;
    logic        ring_has_space;
  } in_item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       open_link;
    logic       close_link;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       buffer_done;
    logic       pending_free;
  } out_item_t;

  typedef struct packed {
    logic        busy;
    logic [23:0] addr;
    logic [23:0] remaining;
  } slot_t;

endpackage

### rtl/core/sfdbr_seq.sv
// Read sequencer state and per-request update logic for the SPI flash reader.
// Depends on sfdbr_pkg.
module sfdbr_seq import sfdbr_pkg::*; #(
  parameter int ADDR_BYTES = 3
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  in_item_t   item,
  input  logic [7:0] read_command,
  output out_item_t  res
);

  localparam logic [1:0] LAST_IDX = 2'(ADDR_BYTES - 1);

  logic       act_r, act_nxt;
  slot_t      slot0_r, slot0_nxt;
  slot_t      slot1_r, slot1_nxt;
  phase_t     phase_r, phase_nxt;
  logic [1:0] idx_r, idx_nxt;

  slot_t       s_act, s_idle;
  logic        swap;
  logic [31:0] addr_ext;
  logic [1:0]  sel;
  logic        finish;

  assign addr_ext = {8'h00, s_act.addr};
  assign sel      = LAST_IDX - idx_r;

  always_comb begin
    s_act     = act_r ? slot1_r : slot0_r;
    s_idle    = act_r ? slot0_r : slot1_r;
    swap      = 1'b0;
    finish    = 1'b0;
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    res       = '0;
    case (item.func)
      FUNC_START: begin
        res.close_link = (phase_r != PH_IDLE);
        s_act  = '0;
        s_idle = '0;
        swap   = !act_r;
      end
      FUNC_FILL: begin
        s_idle.busy      = 1'b1;
        s_idle.addr      = item.flash_addr;
        s_idle.remaining = item.byte_count;
      end
      FUNC_BYTE: begin
        case (phase_r)
          PH_ADDR: begin
            res.tx_valid = 1'b1;
            res.tx_byte  = addr_ext[{sel, 3'b000} +: 8];
            if (idx_r >= LAST_IDX) begin
              phase_nxt = PH_TURN;
              idx_nxt   = 2'd0;
            end else begin
              idx_nxt = idx_r + 2'd1;
            end
          end
          PH_TURN: begin
            phase_nxt = PH_DATA;
            finish    = 1'b1;
          end
          PH_DATA: begin
            res.data_valid = 1'b1;
            res.data_byte  = item.rx_byte;
            if (s_act.remaining != 24'd0) begin
              s_act.remaining = s_act.remaining - 24'd1;
            end
            finish = 1'b1;
          end
          default: begin
          end
        endcase
        if (finish) begin
          if ((s_act.remaining != 24'd0) && item.ring_has_space) begin
            res.tx_valid = 1'b1;
            res.tx_byte  = TX_ZERO;
          end else begin
            res.close_link  = 1'b1;
            res.buffer_done = s_act.busy;
            s_act = '0;
            swap  = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    if ((item.func == FUNC_START) || swap) begin
      phase_nxt     = PH_ADDR;
      idx_nxt       = 2'd0;
      res.open_link = 1'b1;
      res.tx_valid  = 1'b1;
      res.tx_byte   = read_command;
    end
    act_nxt   = act_r ^ swap;
    slot0_nxt = act_r ? s_idle : s_act;
    slot1_nxt = act_r ? s_act : s_idle;
    res.pending_free = swap ? !s_act.busy : !s_idle.busy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r   <= 1'b0;
      slot0_r <= '0;
      slot1_r <= '0;
      phase_r <= PH_IDLE;
      idx_r   <= 2'd0;
    end else if (step_en) begin
      act_r   <= act_nxt;
      slot0_r <= slot0_nxt;
      slot1_r <= slot1_nxt;
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

### rtl/core/spi_flash_double_buffer_reader.sv
// SPI flash double buffer reader: one result per request. A request taken at
// a clock edge is held in the input register and the result register loads from
// it when the output is not stalled; out_valid is driven by the result register.
// Throughput is one request per cycle unless out_stall holds the output.
// Synchronous active-low reset empties both slots, sets the idle phase and
// loads the read command register with 3. Depends on sfdbr_pkg and sfdbr_seq.
module spi_flash_double_buffer_reader import sfdbr_pkg::*; #(
  parameter int ADDR_BYTES = 3
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  logic       in_vld_r;
  in_item_t   in_item_r;
  logic       out_vld_r;
  out_item_t  out_item_r;
  logic [7:0] read_cmd_r;
  logic       adv;
  out_item_t  res;

  assign adv       = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall  = in_vld_r && out_vld_r && out_stall;
  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;
  assign cfg_ready = 1'b1;

  sfdbr_seq #(
    .ADDR_BYTES(ADDR_BYTES)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (adv),
    .item        (in_item_r),
    .read_command(read_cmd_r),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      read_cmd_r <= READ_CMD_RESET;
    end else begin
      if (!in_stall) begin
        in_vld_r <= in_valid;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        read_cmd_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_item_r <= in_data;
    end
    if (adv) begin
      out_item_r <= res;
    end
  end

`include "spi_flash_double_buffer_reader_assert.svh"

  `SFDBR_ASSERT_SAME(a_close_reopens, clk, rst_n, out_vld_r && out_item_r.close_link, out_item_r.open_link)
  `SFDBR_ASSERT_SAME(a_done_closes, clk, rst_n, out_vld_r && out_item_r.buffer_done, out_item_r.close_link)
  `SFDBR_ASSERT_SAME(a_open_sends, clk, rst_n, out_vld_r && out_item_r.open_link, out_item_r.tx_valid)
  `SFDBR_ASSERT_NEXT(a_stall_holds_stage, clk, rst_n, in_stall, in_vld_r)

endmodule
